[rtl/core/itrd_pkg.sv]
// ---------------------------------------------------------------------------
// itrd_pkg: shared types and constants for integer to radix digits
// Widths, division step sizing, job word format, character codes.
// ---------------------------------------------------------------------------
package itrd_pkg;

    // value width and derived sizes
    localparam int VALUE_BITS  = 32;
    localparam int RADIX_BITS  = 8;
    localparam int DIGIT_BITS  = 6;
    localparam int CHAR_BITS   = 7;

    // restoring division: quotient bits resolved per cycle
    localparam int STEP_BITS   = 8;
    localparam int DIV_CYCLES  = (VALUE_BITS + STEP_BITS - 1) / STEP_BITS;
    localparam int PAD_BITS    = DIV_CYCLES * STEP_BITS;
    localparam int DCYC_BITS   = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;

    // digit store sizing
    localparam int IDX_BITS    = $clog2(VALUE_BITS);
    localparam int CNT_BITS    = $clog2(VALUE_BITS + 1);

    // job queue, depth must be a power of two
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    localparam logic [RADIX_BITS-1:0] RADIX_MIN  = RADIX_BITS'(2);
    localparam logic [RADIX_BITS-1:0] RADIX_MAX  = RADIX_BITS'(36);

    localparam logic [CHAR_BITS-1:0]  CHAR_MINUS = CHAR_BITS'(8'h2D);
    localparam logic [CHAR_BITS-1:0]  CHAR_NONE  = '0;
    localparam logic [CHAR_BITS-1:0]  CHAR_ZERO  = CHAR_BITS'(8'h30);
    localparam logic [CHAR_BITS-1:0]  CHAR_ALPHA = CHAR_BITS'(8'h41);

    // one classified conversion job
    typedef struct packed {
        logic                  bad;    // radix out of range
        logic                  neg;    // value was negative
        logic [DIGIT_BITS-1:0] radix;
        logic [VALUE_BITS-1:0] mag;    // magnitude, unsigned
    } t_job;

    // digit value to ascii, 0-9 then A-Z
    function automatic logic [CHAR_BITS-1:0] digit_char(input logic [DIGIT_BITS-1:0] d);
        logic [CHAR_BITS-1:0] dx;
        dx = CHAR_BITS'(d);
        if (d < DIGIT_BITS'(10)) begin
            return CHAR_ZERO + dx;
        end else begin
            return CHAR_ALPHA + dx - CHAR_BITS'(10);
        end
    endfunction

endpackage

[rtl/core/integer_to_radix_digits_top.sv]
// ---------------------------------------------------------------------------
// integer_to_radix_digits_top: signed integer to ascii digits, radix 2..36
// Front classifier, job queue, divider and emitter back end.
// ---------------------------------------------------------------------------
// usage
// - input channel: i_in_valid / o_in_stall carry one word of i_value
//   (signed, two's complement) and i_radix; accepted when valid and not stall
// - output channel: o_out_valid / i_out_stall carry one character per word,
//   most significant first; o_is_last marks the final one
// - negative values lead with '-', then the digits of the magnitude
// - a radix outside 2..36 gives a single word with o_is_empty and o_is_last
// - per value: the job is popped, the digits are found by division (8
//   quotient bits per cycle through one shared restoring divider), the sign
//   is sent when negative, then each digit is read out of the digit store
//   (registered read) and sent
// - a two-entry job queue lets the front take new words while the back works
// - a stalled receiver holds the output word; the emitter waits, the queue
//   fills, then o_in_stall rises
// - reset (i_rst_n low, synchronous) empties the queue and output register
// ---------------------------------------------------------------------------
module integer_to_radix_digits_top
    import itrd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [VALUE_BITS-1:0] i_value,
    input  logic [RADIX_BITS-1:0] i_radix,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [CHAR_BITS-1:0]  o_character,
    output logic                  o_is_last,
    output logic                  o_is_empty
);

    // front to queue
    logic push;
    logic full;
    t_job push_job;

    // queue to back
    logic pop;
    logic job_valid;
    t_job job;

    itrd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_value    (i_value),
        .i_radix    (i_radix),
        .i_full     (full),
        .o_push     (push),
        .o_job      (push_job)
    );

    itrd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (job_valid),
        .o_job   (job)
    );

    itrd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (job_valid),
        .i_job       (job),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_character (o_character),
        .o_is_last   (o_is_last),
        .o_is_empty  (o_is_empty)
    );

endmodule

[rtl/core/itrd_front.sv]
// ---------------------------------------------------------------------------
// itrd_front: input acceptance and classification
// Checks the radix, takes sign and magnitude, pushes one job word.
// ---------------------------------------------------------------------------
module itrd_front
    import itrd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [VALUE_BITS-1:0] i_value,
    input  logic [RADIX_BITS-1:0] i_radix,
    input  logic                  i_full,
    output logic                  o_push,
    output t_job                  o_job
);

    always_comb begin
        o_job.bad   = (i_radix < RADIX_MIN) || (i_radix > RADIX_MAX);
        o_job.neg   = i_value[VALUE_BITS-1];
        o_job.radix = i_radix[DIGIT_BITS-1:0];
        o_job.mag   = o_job.neg ? (~i_value + VALUE_BITS'(1)) : i_value;
    end

    assign o_in_stall = i_full;
    assign o_push     = i_in_valid && !i_full;

    // magnitude of the most negative value keeps only the top bit
    a_min_mag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && i_value == {1'b1, {(VALUE_BITS-1){1'b0}}})
        |-> (o_job.mag == {1'b1, {(VALUE_BITS-1){1'b0}}}))
        else $error("most negative magnitude wrong");

    // a valid radix always fits the narrowed field
    a_radix_fit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && !o_job.bad) |-> (RADIX_BITS'(o_job.radix) == i_radix))
        else $error("radix narrowed wrongly");

    // no push while the queue is full
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_full |-> !o_push)
        else $error("push into full queue");

endmodule

[rtl/core/itrd_queue.sv]
// ---------------------------------------------------------------------------
// itrd_queue: short job queue between front and back
// Small register fifo, lets each side stall on its own.
// ---------------------------------------------------------------------------
module itrd_queue
    import itrd_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_job o_job
);

    t_job                 r_mem [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] r_wr_ptr;
    logic [QPTR_BITS-1:0] r_rd_ptr;
    logic [QCNT_BITS-1:0] r_cnt;
    logic [QCNT_BITS-1:0] n_cnt;
    logic                 do_push;
    logic                 do_pop;

    assign o_full  = (r_cnt == QCNT_BITS'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_job   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_cnt = r_cnt;
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + QCNT_BITS'(1);
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - QCNT_BITS'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_BITS'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_BITS'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

endmodule

[rtl/core/itrd_back.sv]
// ---------------------------------------------------------------------------
// itrd_back: digit extraction and character emission
// Shared restoring divider, digit store, emission sequencer, output word.
// ---------------------------------------------------------------------------
module itrd_back
    import itrd_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_job_valid,
    input  t_job                 i_job,
    output logic                 o_pop,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [CHAR_BITS-1:0] o_character,
    output logic                 o_is_last,
    output logic                 o_is_empty
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_DIV   = 6'b000010,
        S_SIGN  = 6'b000100,
        S_RD    = 6'b001000,
        S_OUT   = 6'b010000,
        S_EMPTY = 6'b100000
    } t_state;

    t_state                r_state, n_state;
    logic [PAD_BITS-1:0]   r_quo, n_quo;
    logic [DIGIT_BITS-1:0] r_rem, n_rem;
    logic [DIGIT_BITS-1:0] r_radix, n_radix;
    logic [DCYC_BITS-1:0]  r_cyc, n_cyc;
    logic [CNT_BITS-1:0]   r_cnt, n_cnt;
    logic                  r_neg, n_neg;
    logic [IDX_BITS-1:0]   r_idx, n_idx;

    logic [DIGIT_BITS-1:0] r_store [VALUE_BITS];
    logic [DIGIT_BITS-1:0] r_rd_data;
    logic                  st_wr;

    logic [DIGIT_BITS-1:0] step_rem;
    logic [STEP_BITS-1:0]  step_q;
    logic [PAD_BITS-1:0]   step_quo;
    logic                  last_cyc;

    logic                  r_out_valid;
    logic [CHAR_BITS-1:0]  r_out_char;
    logic                  r_out_last;
    logic                  r_out_empty;
    logic                  slot_free;
    logic                  ld;
    logic [CHAR_BITS-1:0]  ld_char;
    logic                  ld_last;
    logic                  ld_empty;

    // STEP_BITS restoring steps on the remainder
    always_comb begin
        logic [DIGIT_BITS:0] trial;
        step_rem = r_rem;
        step_q   = '0;
        for (int k = 0; k < STEP_BITS; k++) begin
            trial = {step_rem, r_quo[PAD_BITS-1-k]};
            if (trial >= {1'b0, r_radix}) begin
                step_rem = DIGIT_BITS'(trial - {1'b0, r_radix});
                step_q[STEP_BITS-1-k] = 1'b1;
            end else begin
                step_rem = trial[DIGIT_BITS-1:0];
            end
        end
        step_quo = (r_quo << STEP_BITS) | PAD_BITS'(step_q);
    end

    assign last_cyc  = (r_cyc == DCYC_BITS'(DIV_CYCLES - 1));
    assign slot_free = !r_out_valid || !i_out_stall;
    assign o_pop     = (r_state == S_IDLE) && i_job_valid;
    assign st_wr     = (r_state == S_DIV) && last_cyc;

    always_comb begin
        n_state  = r_state;
        n_quo    = r_quo;
        n_rem    = r_rem;
        n_radix  = r_radix;
        n_cyc    = r_cyc;
        n_cnt    = r_cnt;
        n_neg    = r_neg;
        n_idx    = r_idx;
        ld       = 1'b0;
        ld_char  = CHAR_NONE;
        ld_last  = 1'b0;
        ld_empty = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_job_valid) begin
                    n_cnt = '0;
                    n_rem = '0;
                    n_cyc = '0;
                    if (i_job.bad) begin
                        n_neg   = 1'b0;
                        n_state = S_EMPTY;
                    end else begin
                        n_neg   = i_job.neg;
                        n_radix = i_job.radix;
                        n_quo   = PAD_BITS'(i_job.mag);
                        n_state = S_DIV;
                    end
                end
            end
            S_DIV: begin
                n_quo = step_quo;
                n_rem = step_rem;
                n_cyc = r_cyc + DCYC_BITS'(1);
                if (last_cyc) begin
                    n_rem = '0;
                    n_cyc = '0;
                    n_cnt = r_cnt + CNT_BITS'(1);
                    if (step_quo == '0) begin
                        n_idx   = r_cnt[IDX_BITS-1:0];
                        n_state = r_neg ? S_SIGN : S_RD;
                    end
                end
            end
            S_SIGN: begin
                if (slot_free) begin
                    ld      = 1'b1;
                    ld_char = CHAR_MINUS;
                    n_state = S_RD;
                end
            end
            S_RD: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                if (slot_free) begin
                    ld      = 1'b1;
                    ld_char = digit_char(r_rd_data);
                    ld_last = (r_idx == '0);
                    if (r_idx == '0) begin
                        n_state = S_IDLE;
                    end else begin
                        n_idx   = r_idx - IDX_BITS'(1);
                        n_state = S_RD;
                    end
                end
            end
            S_EMPTY: begin
                if (slot_free) begin
                    ld       = 1'b1;
                    ld_last  = 1'b1;
                    ld_empty = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_neg       <= 1'b0;
            r_cyc       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_neg   <= n_neg;
            r_cyc   <= n_cyc;
            if (ld) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_quo   <= n_quo;
        r_rem   <= n_rem;
        r_radix <= n_radix;
        r_idx   <= n_idx;
        if (ld) begin
            r_out_char  <= ld_char;
            r_out_last  <= ld_last;
            r_out_empty <= ld_empty;
        end
    end

    // digit store, least significant digit first
    always_ff @(posedge i_clk) begin
        if (st_wr) begin
            r_store[r_cnt[IDX_BITS-1:0]] <= step_rem;
        end
        r_rd_data <= r_store[r_idx];
    end

    assign o_out_valid = r_out_valid;
    assign o_character = r_out_char;
    assign o_is_last   = r_out_last;
    assign o_is_empty  = r_out_empty;

    // remainder stays below the radix while dividing
    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_rem < r_radix))
        else $error("remainder not below radix");

    // no digit written past the store
    a_store_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        st_wr |-> (r_cnt < CNT_BITS'(VALUE_BITS)))
        else $error("digit store overflow");

    // emission index stays within the digits found
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RD || r_state == S_OUT) |-> (CNT_BITS'(r_idx) < r_cnt))
        else $error("emission index out of range");

    // an empty word is always the last of its string
    a_empty_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_empty) |-> r_out_last)
        else $error("empty word not marked last");

endmodule
